FILE: sv/rci_pkg.sv
// Shared constants and step functions for the ray/cone intersection core.
// Used by ray_cone_intersect_core; no dependencies.
package rci_pkg;

  localparam int unsigned SQ_STEPS = 32;   // one root bit per stage
  localparam int unsigned DV_STEPS = 49;   // one quotient bit per stage
  localparam int unsigned FRONT_STAGES = 9;
  localparam int unsigned NST = FRONT_STAGES + SQ_STEPS + 1 + DV_STEPS + 1;

  localparam logic [31:0] TAN_SQ_RESET = 32'h0001_0000;
  localparam logic [48:0] DIST_MAX = 49'h0_7FFF_FFFF;

  // One step of the digit-by-digit integer square root: {remainder, root}.
  function automatic logic [127:0] sq_step(logic [63:0] v, logic [63:0] r, logic [63:0] b);
    logic [63:0] t;
    t = r + b;
    if (v >= t) begin
      return {v - t, (r >> 1) + b};
    end else begin
      return {v, r >> 1};
    end
  endfunction

  // One restoring division step: {quotient bit, new remainder}.
  function automatic logic [33:0] dv_step(logic [32:0] rem, logic nb, logic [32:0] d);
    logic [33:0] t;
    t = {rem, nb};
    if (t >= {1'b0, d}) begin
      return {1'b1, 33'(t - {1'b0, d})};
    end else begin
      return {1'b0, t[32:0]};
    end
  endfunction

  // Bit length of a 12-bit group.
  function automatic logic [3:0] bit_len12(logic [11:0] v);
    logic [3:0] n;
    n = 4'd0;
    for (int i = 0; i < 12; i++) begin
      if (v[i]) begin
        n = 4'(i + 1);
      end
    end
    return n;
  endfunction

endpackage

FILE: sv/ray_cone_intersect_core.sv
// Ray against infinite double cone about the z axis, fully pipelined.
// Depends on rci_pkg for stage counts, constants and the root/divide step functions.

// The core accepts one ray per clock unless the output is held, and returns
// one result per ray, in order, through NST = 92 register stages. Most of
// these stages form the two bit-serial chains: a 32-stage square root of
// the discriminant and a 49-stage restoring divider pair that turns the
// candidate numerators into Q16.16 distances. Ahead of them nine stages form
// the products, the quadratic coefficients, their common normalizing shift
// and the discriminant. The whole pipeline advances together: when the
// output request is held by m_tready low, every stage freezes, and s_tready
// drops only in that case, so nothing is lost or repeated. tan_sq is written
// through tan_sq_we and must only change while no ray is in flight; it
// resets to 1.0.
module ray_cone_intersect_core
  import rci_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         tan_sq_we,
  input  logic [31:0]  tan_sq_wdata,
  input  logic         s_tvalid,
  output logic         s_tready,
  // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z (32 bits each, lowest first)
  input  logic [191:0] s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // distance [30:0], zero fill [31]
  output logic [31:0]  m_tdata,
  // hit [0]
  output logic         m_tuser
);

  logic [31:0] tan_sq;
  logic [NST-1:0] vld;
  logic en;

  assign en = !vld[NST-1] || m_tready;
  assign s_tready = en;
  assign m_tvalid = vld[NST-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      tan_sq <= TAN_SQ_RESET;
      vld <= '0;
    end else begin
      if (tan_sq_we) begin
        tan_sq <= tan_sq_wdata;
      end
      if (en) begin
        vld <= {vld[NST-2:0], s_tvalid};
      end
    end
  end

  // Stage 1: the nine raw products.
  logic signed [31:0] ox, oy, oz, dx, dy, dz;
  assign ox = s_tdata[31:0];
  assign oy = s_tdata[63:32];
  assign oz = s_tdata[95:64];
  assign dx = s_tdata[127:96];
  assign dy = s_tdata[159:128];
  assign dz = s_tdata[191:160];

  logic signed [63:0] p1_dxx, p1_dyy, p1_dzz, p1_oxdx, p1_oydy, p1_ozdz, p1_oxx, p1_oyy, p1_ozz;
  always_ff @(posedge clk) begin
    if (en) begin
      p1_dxx <= dx * dx;
      p1_dyy <= dy * dy;
      p1_dzz <= dz * dz;
      p1_oxdx <= ox * dx;
      p1_oydy <= oy * dy;
      p1_ozdz <= oz * dz;
      p1_oxx <= ox * ox;
      p1_oyy <= oy * oy;
      p1_ozz <= oz * oz;
    end
  end

  // Stage 2: radial sums, and the axial terms times tan_sq split in two halves.
  logic [63:0] mzh;
  assign mzh = p1_ozdz[63] ? 64'(-p1_ozdz) : 64'(p1_ozdz);

  logic signed [64:0] p2_xa, p2_xh, p2_xc;
  logic [63:0] p2_za_lo, p2_zh_lo, p2_zc_lo;
  logic [62:0] p2_za_hi, p2_zh_hi, p2_zc_hi;
  logic p2_zh_neg;
  always_ff @(posedge clk) begin
    if (en) begin
      p2_xa <= 65'(p1_dxx) + 65'(p1_dyy);
      p2_xh <= 65'(p1_oxdx) + 65'(p1_oydy);
      p2_xc <= 65'(p1_oxx) + 65'(p1_oyy);
      p2_za_lo <= {32'b0, p1_dzz[31:0]} * {32'b0, tan_sq};
      p2_zh_lo <= {32'b0, mzh[31:0]} * {32'b0, tan_sq};
      p2_zc_lo <= {32'b0, p1_ozz[31:0]} * {32'b0, tan_sq};
      p2_za_hi <= {32'b0, p1_dzz[62:32]} * {31'b0, tan_sq};
      p2_zh_hi <= {32'b0, mzh[62:32]} * {31'b0, tan_sq};
      p2_zc_hi <= {32'b0, p1_ozz[62:32]} * {31'b0, tan_sq};
      p2_zh_neg <= p1_ozdz[63];
    end
  end

  // Stage 3: exact coefficients in units of 2^-48 (H is half the linear term).
  logic [94:0] za_s, zh_s, zc_s;
  logic signed [95:0] xa_w, xh_w, xc_w;
  assign za_s = {p2_za_hi, 32'b0} + {31'b0, p2_za_lo};
  assign zh_s = {p2_zh_hi, 32'b0} + {31'b0, p2_zh_lo};
  assign zc_s = {p2_zc_hi, 32'b0} + {31'b0, p2_zc_lo};
  assign xa_w = {{15{p2_xa[64]}}, p2_xa, 16'b0};
  assign xh_w = {{15{p2_xh[64]}}, p2_xh, 16'b0};
  assign xc_w = {{15{p2_xc[64]}}, p2_xc, 16'b0};

  logic signed [95:0] p3_a, p3_h, p3_c;
  always_ff @(posedge clk) begin
    if (en) begin
      p3_a <= xa_w - $signed({1'b0, za_s});
      p3_h <= p2_zh_neg ? xh_w + $signed({1'b0, zh_s}) : xh_w - $signed({1'b0, zh_s});
      p3_c <= xc_w - $signed({1'b0, zc_s});
    end
  end

  // Stage 4: magnitudes and their union, whose bit length is the largest one.
  logic [95:0] ma_n, mh_n, mc_n;
  assign ma_n = p3_a[95] ? 96'(-p3_a) : 96'(p3_a);
  assign mh_n = p3_h[95] ? 96'(-p3_h) : 96'(p3_h);
  assign mc_n = p3_c[95] ? 96'(-p3_c) : 96'(p3_c);

  logic [94:0] p4_ma, p4_mh, p4_mc, p4_or;
  logic p4_na, p4_nh, p4_nc;
  always_ff @(posedge clk) begin
    if (en) begin
      p4_ma <= ma_n[94:0];
      p4_mh <= mh_n[94:0];
      p4_mc <= mc_n[94:0];
      p4_or <= ma_n[94:0] | mh_n[94:0] | mc_n[94:0];
      p4_na <= p3_a[95];
      p4_nh <= p3_h[95];
      p4_nc <= p3_c[95];
    end
  end

  // Stage 5: bit length within each 12-bit group.
  logic [95:0] or_pad;
  assign or_pad = {1'b0, p4_or};

  logic [94:0] p5_ma, p5_mh, p5_mc;
  logic p5_na, p5_nh, p5_nc;
  logic [3:0] p5_len [0:7];
  always_ff @(posedge clk) begin
    if (en) begin
      p5_ma <= p4_ma;
      p5_mh <= p4_mh;
      p5_mc <= p4_mc;
      p5_na <= p4_na;
      p5_nh <= p4_nh;
      p5_nc <= p4_nc;
      for (int g = 0; g < 8; g++) begin
        p5_len[g] <= bit_len12(or_pad[g*12 +: 12]);
      end
    end
  end

  // Stage 6: overall length from the highest non-empty group, then the shift.
  logic [6:0] len_n, s_n;
  always_comb begin
    len_n = 7'd0;
    for (int g = 0; g < 8; g++) begin
      if (p5_len[g] != 4'd0) begin
        len_n = 7'(g * 12) + 7'(p5_len[g]);
      end
    end
    s_n = (len_n > 7'd31) ? len_n - 7'd31 : 7'd0;
  end

  logic [94:0] p6_ma, p6_mh, p6_mc;
  logic p6_na, p6_nh, p6_nc;
  logic [6:0] p6_s;
  always_ff @(posedge clk) begin
    if (en) begin
      p6_ma <= p5_ma;
      p6_mh <= p5_mh;
      p6_mc <= p5_mc;
      p6_na <= p5_na;
      p6_nh <= p5_nh;
      p6_nc <= p5_nc;
      p6_s <= s_n;
    end
  end

  // Stage 7: normalized coefficients, truncated toward zero.
  logic [94:0] sa, sh, sc;
  assign sa = p6_ma >> p6_s;
  assign sh = p6_mh >> p6_s;
  assign sc = p6_mc >> p6_s;

  logic signed [31:0] p7_a, p7_h, p7_c;
  always_ff @(posedge clk) begin
    if (en) begin
      p7_a <= p6_na ? -$signed(sa[31:0]) : $signed(sa[31:0]);
      p7_h <= p6_nh ? -$signed(sh[31:0]) : $signed(sh[31:0]);
      p7_c <= p6_nc ? -$signed(sc[31:0]) : $signed(sc[31:0]);
    end
  end

  // Stage 8: discriminant products.
  logic signed [63:0] p8_hh, p8_ac;
  logic signed [31:0] p8_a, p8_h, p8_c;
  always_ff @(posedge clk) begin
    if (en) begin
      p8_hh <= p7_h * p7_h;
      p8_ac <= p7_a * p7_c;
      p8_a <= p7_a;
      p8_h <= p7_h;
      p8_c <= p7_c;
    end
  end

  // Stage 9 feeds the square root chain directly (index 0 of its arrays).
  logic [63:0] sq_v [0:SQ_STEPS];
  logic [63:0] sq_r [0:SQ_STEPS];
  logic signed [31:0] sq_a [0:SQ_STEPS];
  logic signed [31:0] sq_h [0:SQ_STEPS];
  logic signed [31:0] sq_c [0:SQ_STEPS];
  logic sq_neg [0:SQ_STEPS];

  logic signed [63:0] disc_n;
  assign disc_n = p8_hh - p8_ac;

  always_ff @(posedge clk) begin
    if (en) begin
      sq_v[0] <= disc_n;
      sq_r[0] <= '0;
      sq_a[0] <= p8_a;
      sq_h[0] <= p8_h;
      sq_c[0] <= p8_c;
      sq_neg[0] <= disc_n[63];
    end
  end

  for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sqrt
    logic [127:0] st;
    assign st = sq_step(sq_v[k], sq_r[k], 64'd1 << (62 - 2 * k));
    always_ff @(posedge clk) begin
      if (en) begin
        sq_v[k+1] <= st[127:64];
        sq_r[k+1] <= st[63:0];
        sq_a[k+1] <= sq_a[k];
        sq_h[k+1] <= sq_h[k];
        sq_c[k+1] <= sq_c[k];
        sq_neg[k+1] <= sq_neg[k];
      end
    end
  end

  // Candidate roots. A zero leading term uses the linear root -c/(2h) in
  // slot 0; otherwise the slots hold (-h + q)/a and (-h - q)/a.
  logic signed [31:0] fa, fh, fc;
  logic signed [34:0] qs, hs, n1, n2;
  logic [34:0] n1m, n2m;
  logic [31:0] am, hm, cm;
  logic ok0_n, ok1_n;
  logic [32:0] nm0_n, nm1_n, den_n;

  assign fa = sq_a[SQ_STEPS];
  assign fh = sq_h[SQ_STEPS];
  assign fc = sq_c[SQ_STEPS];
  assign qs = $signed({2'b0, sq_r[SQ_STEPS][32:0]});
  assign hs = 35'(fh);
  assign n1 = qs - hs;
  assign n2 = -hs - qs;
  assign n1m = n1[34] ? 35'(-n1) : 35'(n1);
  assign n2m = n2[34] ? 35'(-n2) : 35'(n2);
  assign am = fa[31] ? 32'(-fa) : 32'(fa);
  assign hm = fh[31] ? 32'(-fh) : 32'(fh);
  assign cm = fc[31] ? 32'(-fc) : 32'(fc);

  always_comb begin
    if (fa == 32'sd0) begin
      ok0_n = (fh != 32'sd0) && ((fc == 32'sd0) || (fc[31] == !fh[31]));
      ok1_n = 1'b0;
      nm0_n = {1'b0, cm};
      nm1_n = '0;
      den_n = {hm, 1'b0};
    end else begin
      ok0_n = !sq_neg[SQ_STEPS] && ((n1 == 35'sd0) || (n1[34] == fa[31]));
      ok1_n = !sq_neg[SQ_STEPS] && ((n2 == 35'sd0) || (n2[34] == fa[31]));
      nm0_n = n1m[32:0];
      nm1_n = n2m[32:0];
      den_n = {1'b0, am};
    end
  end

  logic [48:0] dv_n0 [0:DV_STEPS];
  logic [48:0] dv_n1 [0:DV_STEPS];
  logic [48:0] dv_q0 [0:DV_STEPS];
  logic [48:0] dv_q1 [0:DV_STEPS];
  logic [32:0] dv_r0 [0:DV_STEPS];
  logic [32:0] dv_r1 [0:DV_STEPS];
  logic [32:0] dv_d [0:DV_STEPS];
  logic dv_ok0 [0:DV_STEPS];
  logic dv_ok1 [0:DV_STEPS];

  always_ff @(posedge clk) begin
    if (en) begin
      dv_n0[0] <= {nm0_n, 16'b0};
      dv_n1[0] <= {nm1_n, 16'b0};
      dv_q0[0] <= '0;
      dv_q1[0] <= '0;
      dv_r0[0] <= '0;
      dv_r1[0] <= '0;
      dv_d[0] <= den_n;
      dv_ok0[0] <= ok0_n;
      dv_ok1[0] <= ok1_n;
    end
  end

  for (genvar k = 0; k < DV_STEPS; k++) begin : g_div
    logic [33:0] st0, st1;
    assign st0 = dv_step(dv_r0[k], dv_n0[k][48], dv_d[k]);
    assign st1 = dv_step(dv_r1[k], dv_n1[k][48], dv_d[k]);
    always_ff @(posedge clk) begin
      if (en) begin
        dv_n0[k+1] <= {dv_n0[k][47:0], 1'b0};
        dv_n1[k+1] <= {dv_n1[k][47:0], 1'b0};
        dv_q0[k+1] <= {dv_q0[k][47:0], st0[33]};
        dv_q1[k+1] <= {dv_q1[k][47:0], st1[33]};
        dv_r0[k+1] <= st0[32:0];
        dv_r1[k+1] <= st1[32:0];
        dv_d[k+1] <= dv_d[k];
        dv_ok0[k+1] <= dv_ok0[k];
        dv_ok1[k+1] <= dv_ok1[k];
      end
    end
  end

  // Output register: nearest counted root, saturated; zero on a miss.
  logic [48:0] q0, q1, best;
  logic ok0, ok1;
  assign q0 = dv_q0[DV_STEPS];
  assign q1 = dv_q1[DV_STEPS];
  assign ok0 = dv_ok0[DV_STEPS];
  assign ok1 = dv_ok1[DV_STEPS];

  always_comb begin
    if (ok0 && ok1) begin
      best = (q1 < q0) ? q1 : q0;
    end else if (ok0) begin
      best = q0;
    end else if (ok1) begin
      best = q1;
    end else begin
      best = '0;
    end
    if (best > DIST_MAX) begin
      best = DIST_MAX;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_tuser <= ok0 || ok1;
      m_tdata <= {1'b0, best[30:0]};
    end
  end

endmodule

FILE: sv/rci_checker.sv
// Port-level checks for ray_cone_intersect_core, attached by bind.
// Depends on the core's port list only.
module rci_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata,
  input logic        m_tuser
);

  // A held result keeps its value.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

  // A miss reports zero distance.
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tdata == 32'd0)
    else $error("miss with nonzero distance");

  // The distance never exceeds the saturation limit.
  a_sat: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !m_tdata[31])
    else $error("distance above limit");

  // Input side only stalls when a result waits.
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid || m_tready |-> s_tready)
    else $error("input stalled with free output");

  // Reset empties the pipeline.
  a_reset: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result right after reset");

endmodule

bind ray_cone_intersect_core rci_checker u_rci_checker (
  .clk(clk),
  .rst(rst),
  .s_tready(s_tready),
  .m_tvalid(m_tvalid),
  .m_tready(m_tready),
  .m_tdata(m_tdata),
  .m_tuser(m_tuser)
);
